### rtl/hcpf_pkg.sv
// package: payload types, pipeline stage records, register codes and slope lookup
`default_nettype none

package hcpf_pkg;

    localparam int unsigned LEVEL_W  = 8;
    localparam int unsigned RATIO_W  = 9;
    localparam int unsigned INDEX_W  = 2;
    localparam int unsigned TERM_W   = 16;
    localparam int unsigned RAMP_W   = 24;

    localparam logic [RATIO_W-1:0] RATIO_MAX   = 9'd256;
    localparam logic [LEVEL_W-1:0] FULL_SCALE  = 8'd255;
    localparam logic [6:0]         MID_LEVEL   = 7'd127;

    localparam logic [RATIO_W-1:0] RATIO_RESET = 9'd128;
    localparam logic [LEVEL_W-1:0] THR_LOW_RESET  = 8'd85;
    localparam logic [LEVEL_W-1:0] THR_HIGH_RESET = 8'd170;

    // register indexes
    localparam logic [INDEX_W-1:0] CFG_BLEND_RATIO    = 2'd0;
    localparam logic [INDEX_W-1:0] CFG_THRESHOLD_LOW  = 2'd1;
    localparam logic [INDEX_W-1:0] CFG_THRESHOLD_HIGH = 2'd2;

    typedef enum logic [1:0] {
        SEG_RED,
        SEG_GREEN,
        SEG_BLUE
    } seg_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] base_level;
        logic [LEVEL_W-1:0] overlay_level;
    } pix_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] red;
        logic [LEVEL_W-1:0] green;
        logic [LEVEL_W-1:0] blue;
    } rgb_t;

    // live configuration as seen by the datapath
    typedef struct packed {
        logic [RATIO_W-1:0] ratio;     // saturated base weight
        logic [RATIO_W-1:0] weight;    // overlay weight
        logic [LEVEL_W-1:0] thr_low;
        logic [LEVEL_W-1:0] thr_high;
    } cfg_t;

    typedef struct packed {
        seg_t               seg;
        logic [LEVEL_W-1:0] base;
        logic [LEVEL_W-1:0] offset;
        logic [LEVEL_W-1:0] slope;
        logic [RATIO_W-1:0] ratio;
        logic [RATIO_W-1:0] weight;
    } cls_t;

    typedef struct packed {
        seg_t               seg;
        logic [TERM_W-1:0]  base_term;
        logic [TERM_W-1:0]  ramp;
        logic [RATIO_W-1:0] weight;
    } prd_t;

    typedef struct packed {
        seg_t               seg;
        logic [TERM_W-1:0]  base_term;
        logic [RAMP_W-1:0]  ramp_term;
        logic [TERM_W-1:0]  half_term;
    } mix_t;

    // floor(255 / width), zero width gives zero slope
    function automatic logic [LEVEL_W-1:0] slope_of(input logic [LEVEL_W-1:0] width);
        if (width == 8'd0)        slope_of = 8'd0;
        else if (width >= 8'd128) slope_of = 8'd1;
        else if (width >= 8'd86)  slope_of = 8'd2;
        else if (width >= 8'd64)  slope_of = 8'd3;
        else if (width >= 8'd52)  slope_of = 8'd4;
        else if (width >= 8'd43)  slope_of = 8'd5;
        else if (width >= 8'd37)  slope_of = 8'd6;
        else if (width >= 8'd32)  slope_of = 8'd7;
        else if (width >= 8'd29)  slope_of = 8'd8;
        else if (width >= 8'd26)  slope_of = 8'd9;
        else if (width >= 8'd24)  slope_of = 8'd10;
        else if (width >= 8'd22)  slope_of = 8'd11;
        else if (width >= 8'd20)  slope_of = 8'd12;
        else if (width == 8'd19)  slope_of = 8'd13;
        else if (width == 8'd18)  slope_of = 8'd14;
        else if (width >= 8'd16)  slope_of = 8'd15;
        else if (width == 8'd15)  slope_of = 8'd17;
        else if (width == 8'd14)  slope_of = 8'd18;
        else if (width == 8'd13)  slope_of = 8'd19;
        else if (width == 8'd12)  slope_of = 8'd21;
        else if (width == 8'd11)  slope_of = 8'd23;
        else if (width == 8'd10)  slope_of = 8'd25;
        else if (width == 8'd9)   slope_of = 8'd28;
        else if (width == 8'd8)   slope_of = 8'd31;
        else if (width == 8'd7)   slope_of = 8'd36;
        else if (width == 8'd6)   slope_of = 8'd42;
        else if (width == 8'd5)   slope_of = 8'd51;
        else if (width == 8'd4)   slope_of = 8'd63;
        else if (width == 8'd3)   slope_of = 8'd85;
        else if (width == 8'd2)   slope_of = 8'd127;
        else                      slope_of = 8'd255;
    endfunction

endpackage

`default_nettype wire

### rtl/hot_colormap_pixel_fusion_core.sv
// top level: hot colormap overlay fused onto a gray base image, four-stage pipeline
//
// usage
//   pix channel: one transaction carries a base gray level and an overlay gray level
//   rgb channel: one transaction carries the fused red, green and blue bytes
//   both channels are valid/ready; a transaction completes when both are high
//   every pixel transaction produces exactly one rgb transaction, in order
//   throughput: one pixel per clock, sustained while rgb_ready is high, no bubbles
//   path: a pixel taken on pix passes the classify, product, weighting and
//     blend/output stage registers in order before it is offered on rgb
//   stall: when rgb_ready is low the stages fill one by one; pix_ready falls
//     only when all four stage registers hold a pixel, nothing is dropped
//   config: cfg_wr_en writes cfg_data into register cfg_index (ratio,
//     low threshold, high threshold); write only while the pipeline is empty
//   reset: rst_n clears all stage valid bits and loads ratio 128 and
//     thresholds 85 and 170; the pipeline accepts pixels straight away
//   one clock per pixel while rgb_ready is high: every stage is a single
//     register; the 8x9 and 8x8 products share a stage, the 16x9 weighting its own
`default_nettype none

module hot_colormap_pixel_fusion_core (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [hcpf_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [hcpf_pkg::RATIO_W-1:0] cfg_data,
    input  wire logic                         pix_valid,
    output logic                              pix_ready,
    input  wire hcpf_pkg::pix_t               pix_data,
    output logic                              rgb_valid,
    input  wire logic                         rgb_ready,
    output hcpf_pkg::rgb_t                    rgb_data
);
    import hcpf_pkg::*;

    // pipeline depth in stage registers
    localparam int unsigned STAGES = 4;

    cfg_t  cfg;
    logic  cls_valid;
    logic  cls_ready;
    cls_t  cls_data;
    logic  mix_valid;
    logic  mix_ready;
    mix_t  mix_data;

    // live registers feed the first stage directly
    hcpf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // stage 1: which colormap segment, offset into it, slope of it
    hcpf_classify u_classify (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .pix_valid (pix_valid),
        .pix_ready (pix_ready),
        .pix_data  (pix_data),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls_data  (cls_data)
    );

    // stages 2 and 3: g*r and ramp, then weighted overlay terms
    hcpf_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (cls_valid),
        .cls_ready (cls_ready),
        .cls_data  (cls_data),
        .mix_valid (mix_valid),
        .mix_ready (mix_ready),
        .mix_data  (mix_data)
    );

    // stage 4: sums, truncation, saturation and channel routing
    hcpf_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .mix_valid (mix_valid),
        .mix_ready (mix_ready),
        .mix_data  (mix_data),
        .rgb_valid (rgb_valid),
        .rgb_ready (rgb_ready),
        .rgb_data  (rgb_data)
    );

    // transactions in flight, for the checks below
    logic [2:0] occ_reg;
    logic       pix_take;
    logic       rgb_take;

    assign pix_take = pix_valid && pix_ready;
    assign rgb_take = rgb_valid && rgb_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            occ_reg <= 3'd0;
        else if (pix_take && !rgb_take)
            occ_reg <= occ_reg + 3'd1;
        else if (rgb_take && !pix_take)
            occ_reg <= occ_reg - 3'd1;
    end

    // never more pixels inside than stage registers
    assert property (@(posedge clk) disable iff (!rst_n) occ_reg <= 3'(STAGES))
        else $error("pipeline holds more pixels than stages");

    // no result without a pixel behind it
    assert property (@(posedge clk) disable iff (!rst_n) rgb_valid |-> occ_reg != 3'd0)
        else $error("result offered with empty pipeline");

    // back-pressure only once the pipeline is full and the output stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !pix_ready |-> (rgb_valid && !rgb_ready && occ_reg == 3'(STAGES)))
        else $error("input stalled while pipeline has room");

    // an empty pipeline always takes a pixel
    assert property (@(posedge clk) disable iff (!rst_n) occ_reg == 3'd0 |-> pix_ready)
        else $error("empty pipeline refuses input");

endmodule

`default_nettype wire

### rtl/hcpf_cfg_regs.sv
// configuration registers with ratio saturation and overlay weight
`default_nettype none

module hcpf_cfg_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_wr_en,
    input  wire logic [hcpf_pkg::INDEX_W-1:0] cfg_index,
    input  wire logic [hcpf_pkg::RATIO_W-1:0] cfg_data,
    output hcpf_pkg::cfg_t                    cfg
);
    import hcpf_pkg::*;

    logic [RATIO_W-1:0] ratio_reg;
    logic [LEVEL_W-1:0] thr_low_reg;
    logic [LEVEL_W-1:0] thr_high_reg;
    logic [RATIO_W-1:0] ratio_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg    <= RATIO_RESET;
            thr_low_reg  <= THR_LOW_RESET;
            thr_high_reg <= THR_HIGH_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_BLEND_RATIO:    ratio_reg    <= cfg_data;
                CFG_THRESHOLD_LOW:  thr_low_reg  <= cfg_data[LEVEL_W-1:0];
                CFG_THRESHOLD_HIGH: thr_high_reg <= cfg_data[LEVEL_W-1:0];
                default:            ;
            endcase
        end
    end

    assign ratio_sat = (ratio_reg > RATIO_MAX) ? RATIO_MAX : ratio_reg;

    always_comb
    begin
        cfg.ratio    = ratio_sat;
        cfg.weight   = RATIO_MAX - ratio_sat;
        cfg.thr_low  = thr_low_reg;
        cfg.thr_high = thr_high_reg;
    end

endmodule

`default_nettype wire

### rtl/hcpf_classify.sv
// first pipeline stage: segment choice, ramp offset and slope lookup
`default_nettype none

module hcpf_classify (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire hcpf_pkg::cfg_t cfg,
    input  wire logic           pix_valid,
    output logic                pix_ready,
    input  wire hcpf_pkg::pix_t pix_data,
    output logic                cls_valid,
    input  wire logic           cls_ready,
    output hcpf_pkg::cls_t      cls_data
);
    import hcpf_pkg::*;

    logic               valid_reg;
    cls_t               data_reg;
    cls_t               data_next;
    logic [LEVEL_W-1:0] seg_width;
    logic [LEVEL_W-1:0] level;

    assign level = pix_data.overlay_level;

    always_comb
    begin
        data_next.base   = pix_data.base_level;
        data_next.ratio  = cfg.ratio;
        data_next.weight = cfg.weight;
        if (level < cfg.thr_low)
        begin
            data_next.seg    = SEG_RED;
            data_next.offset = level;
            seg_width        = cfg.thr_low;
        end
        else if (level < cfg.thr_high)
        begin
            data_next.seg    = SEG_GREEN;
            data_next.offset = level - cfg.thr_low;
            seg_width        = (cfg.thr_high > cfg.thr_low) ? cfg.thr_high - cfg.thr_low
                                                            : 8'd0;
        end
        else
        begin
            data_next.seg    = SEG_BLUE;
            data_next.offset = level - cfg.thr_high;
            seg_width        = FULL_SCALE - cfg.thr_high;
        end
        data_next.slope = slope_of(seg_width);
    end

    assign pix_ready = !valid_reg || cls_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (pix_ready)
            valid_reg <= pix_valid;
    end

    always_ff @(posedge clk)
    begin
        if (pix_ready && pix_valid)
            data_reg <= data_next;
    end

    assign cls_valid = valid_reg;
    assign cls_data  = data_reg;

endmodule

`default_nettype wire

### rtl/hcpf_product.sv
// second and third pipeline stages: base and ramp products, then overlay weighting
`default_nettype none

module hcpf_product (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           cls_valid,
    output logic                cls_ready,
    input  wire hcpf_pkg::cls_t cls_data,
    output logic                mix_valid,
    input  wire logic           mix_ready,
    output hcpf_pkg::mix_t      mix_data
);
    import hcpf_pkg::*;

    logic  prd_valid_reg;
    prd_t  prd_reg;
    prd_t  prd_next;
    logic  prd_ready;
    logic  mix_valid_reg;
    mix_t  mix_reg;
    mix_t  mix_next;

    // g * r and offset * slope side by side
    always_comb
    begin
        prd_next.seg       = cls_data.seg;
        prd_next.base_term = TERM_W'(cls_data.base * cls_data.ratio);
        prd_next.ramp      = TERM_W'(cls_data.offset * cls_data.slope);
        prd_next.weight    = cls_data.weight;
    end

    // overlay terms scaled by the overlay weight
    always_comb
    begin
        mix_next.seg       = prd_reg.seg;
        mix_next.base_term = prd_reg.base_term;
        mix_next.ramp_term = RAMP_W'(prd_reg.ramp * prd_reg.weight);
        mix_next.half_term = TERM_W'(MID_LEVEL * prd_reg.weight);
    end

    assign prd_ready = !mix_valid_reg || mix_ready;
    assign cls_ready = !prd_valid_reg || prd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prd_valid_reg <= 1'b0;
            mix_valid_reg <= 1'b0;
        end
        else
        begin
            if (cls_ready)
                prd_valid_reg <= cls_valid;
            if (prd_ready)
                mix_valid_reg <= prd_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cls_ready && cls_valid)
            prd_reg <= prd_next;
        if (prd_ready && prd_valid_reg)
            mix_reg <= mix_next;
    end

    assign mix_valid = mix_valid_reg;
    assign mix_data  = mix_reg;

endmodule

`default_nettype wire

### rtl/hcpf_blend.sv
// last pipeline stage: blend sums, saturation, channel routing, output register
`default_nettype none

module hcpf_blend (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           mix_valid,
    output logic                mix_ready,
    input  wire hcpf_pkg::mix_t mix_data,
    output logic                rgb_valid,
    input  wire logic           rgb_ready,
    output hcpf_pkg::rgb_t      rgb_data
);
    import hcpf_pkg::*;

    logic               valid_reg;
    rgb_t               data_reg;
    rgb_t               data_next;
    logic [TERM_W:0]    half_sum;
    logic [RAMP_W:0]    ramp_sum;
    logic [LEVEL_W-1:0] plain;
    logic [LEVEL_W-1:0] half;
    logic [LEVEL_W-1:0] ramped;

    always_comb
    begin
        half_sum = {1'b0, mix_data.base_term} + {1'b0, mix_data.half_term};
        ramp_sum = {{(RAMP_W-TERM_W+1){1'b0}}, mix_data.base_term}
                 + {1'b0, mix_data.ramp_term};
        plain    = mix_data.base_term[TERM_W-1:LEVEL_W];
        half     = half_sum[TERM_W-1:LEVEL_W];
        // clamp once the shifted sum passes full scale
        ramped   = (|ramp_sum[RAMP_W:TERM_W]) ? FULL_SCALE
                                              : ramp_sum[TERM_W-1:LEVEL_W];
        case (mix_data.seg)
            SEG_RED:
            begin
                data_next.red   = ramped;
                data_next.green = plain;
                data_next.blue  = plain;
            end
            SEG_GREEN:
            begin
                data_next.red   = half;
                data_next.green = ramped;
                data_next.blue  = plain;
            end
            SEG_BLUE:
            begin
                data_next.red   = half;
                data_next.green = half;
                data_next.blue  = ramped;
            end
            default:
            begin
                data_next.red   = half;
                data_next.green = half;
                data_next.blue  = ramped;
            end
        endcase
    end

    assign mix_ready = !valid_reg || rgb_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (mix_ready)
            valid_reg <= mix_valid;
    end

    always_ff @(posedge clk)
    begin
        if (mix_ready && mix_valid)
            data_reg <= data_next;
    end

    assign rgb_valid = valid_reg;
    assign rgb_data  = data_reg;

endmodule

`default_nettype wire
